FILE: src/assert_macros.svh
// Assertion macros used by the checker in mbe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define MBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MBE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: src/mbe_pkg.sv
package mbe_pkg;

    // Fixed-point format and counter widths.
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 17;

    localparam int IN_W      = 31;
    localparam int VAL_W     = 48;
    localparam int HALF_W    = VAL_W / 2;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ESC_W     = 8;
    localparam int ITER_W    = 16;
    localparam int CNT_W     = ITER_W + 1;
    localparam int MOD_W     = 5;
    localparam int GLYPH_W   = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int THR_W     = ESC_W + FRAC_BITS;
    localparam int SAT_W     = 33;

    localparam int GLYPH_MOD   = 26;
    localparam int GLYPH_BASE  = 64;
    localparam int GLYPH_SPACE = 32;

    localparam logic [ESC_W-1:0]  ESC_RESET  = 8'd4;
    localparam logic [ITER_W-1:0] ITER_RESET = 16'd255;

    localparam logic [SAT_W-1:0] COUNT_MAX = (SAT_W'(1) << COUNT_WIDTH) - SAT_W'(1);
    localparam int SAT_MOD = int'(COUNT_MAX % GLYPH_MOD);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W+1:0] WIDE_MAX = {3'b000, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W+1:0] WIDE_MIN = {3'b111, {(VAL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE_LIMIT    = 1'b0,
        REG_ITERATION_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPER,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ACC,
        S_FIN,
        S_UPD1,
        S_UPD2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       oper;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       acc_en;
        logic       fin;
        logic       upd1;
        logic       upd2;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic finished;
        logic out_free;
    } dp_status_t;

    // Clamp a widened sum to the signed 48-bit range.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > WIDE_MAX) begin
            r = VAL_MAX;
        end else if (x < WIDE_MIN) begin
            r = VAL_MIN;
        end else begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/mbe_fxmul.sv
module mbe_fxmul (
    input  logic                               aclk,
    input  logic                               load,
    input  logic signed [mbe_pkg::VAL_W-1:0]   a,
    input  logic signed [mbe_pkg::VAL_W-1:0]   b,
    input  logic                               mul_en,
    input  logic [1:0]                         mul_phase,
    input  logic                               acc_en,
    input  logic                               fin,
    output logic signed [mbe_pkg::VAL_W-1:0]   prod
);
    import mbe_pkg::*;

    logic [VAL_W-1:0]        ma_reg, mb_reg;
    logic                    neg_reg;
    logic [VAL_W-1:0]        pp_reg;
    logic [1:0]              pp_phase_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic signed [VAL_W-1:0] prod_reg;

    logic [HALF_W-1:0]       a_half, b_half;
    logic [PROD_W-1:0]       pp_shifted;
    logic [PROD_W-1:0]       shifted, cap, mag_sat;
    logic [VAL_W-1:0]        mag_res;
    logic signed [VAL_W-1:0] prod_next;

    // Magnitude times magnitude as four 24x24 partial products.
    assign a_half = mul_phase[1] ? ma_reg[VAL_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign b_half = mul_phase[0] ? mb_reg[VAL_W-1:HALF_W] : mb_reg[HALF_W-1:0];

    always_comb begin
        case (pp_phase_reg)
            2'b00:   pp_shifted = PROD_W'(pp_reg);
            2'b01,
            2'b10:   pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'b11:   pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    // Truncate toward zero, clamp the magnitude, then restore the sign.
    always_comb begin
        shifted = acc_reg >> FRAC_BITS;
        cap     = neg_reg ? PROD_W'({1'b1, {(VAL_W-1){1'b0}}})
                          : PROD_W'({1'b0, {(VAL_W-1){1'b1}}});
        mag_sat = (shifted > cap) ? cap : shifted;
        mag_res = mag_sat[VAL_W-1:0];
        prod_next = neg_reg ? $signed(VAL_W'(0) - mag_res) : $signed(mag_res);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ma_reg  <= a[VAL_W-1] ? VAL_W'(0) - VAL_W'(a) : VAL_W'(a);
            mb_reg  <= b[VAL_W-1] ? VAL_W'(0) - VAL_W'(b) : VAL_W'(b);
            neg_reg <= a[VAL_W-1] ^ b[VAL_W-1];
            acc_reg <= '0;
        end else if (acc_en) begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (mul_en) begin
            pp_reg       <= VAL_W'(a_half) * VAL_W'(b_half);
            pp_phase_reg <= mul_phase;
        end
        if (fin) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: src/mbe_datapath.sv
module mbe_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]            cfg_data,
    input  logic signed [mbe_pkg::IN_W-1:0]      s_point_real,
    input  logic signed [mbe_pkg::IN_W-1:0]      s_point_imag,
    input  mbe_pkg::dp_cmd_t                     cmd,
    output mbe_pkg::dp_status_t                  status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mbe_pkg::COUNT_WIDTH-1:0]      m_escape_count,
    output logic [mbe_pkg::GLYPH_W-1:0]          m_glyph_code
);
    import mbe_pkg::*;

    logic [ESC_W-1:0]        esc_limit_reg;
    logic [ITER_W-1:0]       iter_limit_reg;

    logic signed [VAL_W-1:0] cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [VAL_W-1:0] d_reg, e_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [CNT_W-1:0]        count_reg, res_cnt_reg;
    logic [MOD_W-1:0]        mod_reg, res_mod_reg;

    logic                    m_valid_reg;
    logic [COUNT_WIDTH-1:0]  out_cnt_reg;
    logic [GLYPH_W-1:0]      out_glyph_reg;

    logic signed [VAL_W-1:0] rr, ri, rc;
    logic [VAL_W:0]          mag_sum;
    logic                    escape, over;
    logic [CNT_W-1:0]        count_inc;
    logic [MOD_W-1:0]        mod_inc;
    logic [SAT_W-1:0]        cnt_wide, cnt_sat;
    logic [MOD_W-1:0]        mod_sat;
    logic [GLYPH_W-1:0]      glyph_next;

    mbe_fxmul u_mul_rr (
        .aclk      (aclk),
        .load      (cmd.oper),
        .a         (zr_reg),
        .b         (zr_reg),
        .mul_en    (cmd.mul_en),
        .mul_phase (cmd.mul_phase),
        .acc_en    (cmd.acc_en),
        .fin       (cmd.fin),
        .prod      (rr)
    );

    mbe_fxmul u_mul_ri (
        .aclk      (aclk),
        .load      (cmd.oper),
        .a         (zi_reg),
        .b         (zi_reg),
        .mul_en    (cmd.mul_en),
        .mul_phase (cmd.mul_phase),
        .acc_en    (cmd.acc_en),
        .fin       (cmd.fin),
        .prod      (ri)
    );

    mbe_fxmul u_mul_rc (
        .aclk      (aclk),
        .load      (cmd.oper),
        .a         (zr_reg),
        .b         (zi_reg),
        .mul_en    (cmd.mul_en),
        .mul_phase (cmd.mul_phase),
        .acc_en    (cmd.acc_en),
        .fin       (cmd.fin),
        .prod      (rc)
    );

    // Both squares are non-negative, so the escape sum is exact as unsigned.
    always_comb begin
        mag_sum   = {1'b0, rr} + {1'b0, ri};
        escape    = mag_sum > (VAL_W + 1)'(thr_reg);
        count_inc = count_reg + CNT_W'(1);
        mod_inc   = (mod_reg == MOD_W'(GLYPH_MOD - 1)) ? '0 : mod_reg + MOD_W'(1);
        over      = count_inc > CNT_W'(iter_limit_reg);
    end

    assign status.finished = escape | over;
    assign status.out_free = ~m_valid_reg | m_ready;

    // Clamp the count to the output width; the residue follows the clamp.
    always_comb begin
        cnt_wide = SAT_W'(res_cnt_reg);
        if (cnt_wide > COUNT_MAX) begin
            cnt_sat = COUNT_MAX;
            mod_sat = MOD_W'(SAT_MOD);
        end else begin
            cnt_sat = cnt_wide;
            mod_sat = res_mod_reg;
        end
        glyph_next = (mod_sat == '0) ? GLYPH_W'(GLYPH_SPACE)
                                     : GLYPH_W'(GLYPH_BASE) + GLYPH_W'(mod_sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_limit_reg  <= ESC_RESET;
            iter_limit_reg <= ITER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ESCAPE_LIMIT:    esc_limit_reg  <= cfg_data[ESC_W-1:0];
                REG_ITERATION_LIMIT: iter_limit_reg <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cr_reg    <= VAL_W'(s_point_real);
            ci_reg    <= VAL_W'(s_point_imag);
            thr_reg   <= THR_W'(esc_limit_reg) << FRAC_BITS;
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
            mod_reg   <= '0;
        end
        if (cmd.upd1) begin
            d_reg       <= sat_val((VAL_W + 2)'(rr) - (VAL_W + 2)'(ri));
            e_reg       <= sat_val((VAL_W + 2)'(rc) + (VAL_W + 2)'(rc));
            count_reg   <= count_inc;
            mod_reg     <= mod_inc;
            res_cnt_reg <= escape ? count_inc : '0;
            res_mod_reg <= escape ? mod_inc : '0;
        end
        if (cmd.upd2) begin
            zr_reg <= sat_val((VAL_W + 2)'(d_reg) + (VAL_W + 2)'(cr_reg));
            zi_reg <= sat_val((VAL_W + 2)'(e_reg) + (VAL_W + 2)'(ci_reg));
        end
        if (cmd.out_load) begin
            out_cnt_reg   <= cnt_sat[COUNT_WIDTH-1:0];
            out_glyph_reg <= glyph_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = out_cnt_reg;
    assign m_glyph_code   = out_glyph_reg;

endmodule

FILE: src/mbe_ctrl.sv
module mbe_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbe_pkg::dp_status_t  status,
    output mbe_pkg::dp_cmd_t     cmd
);
    import mbe_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_OPER;
                end
            end
            S_OPER:  state_next = S_MUL0;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_ACC;
            S_ACC:   state_next = S_FIN;
            S_FIN:   state_next = S_UPD1;
            S_UPD1:  state_next = status.finished ? S_DONE : S_UPD2;
            S_UPD2:  state_next = S_OPER;
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_OPER: cmd.oper = 1'b1;
            S_MUL0: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd0;
            end
            S_MUL1: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd1;
                cmd.acc_en    = 1'b1;
            end
            S_MUL2: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd2;
                cmd.acc_en    = 1'b1;
            end
            S_MUL3: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd3;
                cmd.acc_en    = 1'b1;
            end
            S_ACC:  cmd.acc_en   = 1'b1;
            S_FIN:  cmd.fin      = 1'b1;
            S_UPD1: cmd.upd1     = 1'b1;
            S_UPD2: cmd.upd2     = 1'b1;
            S_DONE: cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: src/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit. Each input transaction carries one point c in
// signed fixed point (FRAC_BITS fraction bits, Q3.28 by default); the unit
// iterates z = z*z + c from z = 0 in saturating 48-bit arithmetic and returns
// one output transaction with the escape count (0 if iteration_limit is passed
// first) and a glyph code: 32 when the count is a multiple of 26, otherwise
// 64 plus the count modulo 26. An iteration computes three 48x48 products,
// each built from four 24x24 partial products through one multiplier per
// product. The last iteration skips the update of z. An item's result is
// loaded into the output register once that register is free, and the next
// point can be accepted in the cycle after; one item is processed at a time.
// The result sits in an output register, so the next point is accepted as
// soon as the result is loaded, even while it waits for m_ready.
// The configuration registers (index 0: escape_limit, reset 4; index 1:
// iteration_limit, reset 255) must only be written while the unit is idle.
module mandelbrot_escape_time (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]         cfg_data,
    // Input point channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_point_real,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_point_imag,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbe_pkg::COUNT_WIDTH-1:0]   m_escape_count,
    output logic [mbe_pkg::GLYPH_W-1:0]       m_glyph_code
);
    import mbe_pkg::*;

    // The controller sequences the iteration steps; the datapath holds the
    // configuration, the point, z, the counters and the output register.
    dp_cmd_t    cmd;
    dp_status_t status;

    mbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mbe_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_point_real   (s_point_real),
        .s_point_imag   (s_point_imag),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_glyph_code   (m_glyph_code)
    );

endmodule

FILE: src/mbe_checker.sv
`include "assert_macros.svh"

module mbe_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [mbe_pkg::COUNT_WIDTH-1:0]  m_escape_count,
    input logic [mbe_pkg::GLYPH_W-1:0]      m_glyph_code
);
    import mbe_pkg::*;

    // No result is offered right after reset.
    `MBE_ASSERT_ALWAYS(a_rst_no_result, !aresetn |=> !m_valid, "result valid after reset")

    // A held result keeps its payload.
    `MBE_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_escape_count) && $stable(m_glyph_code), "result changed while stalled")

    // Only one point is in work, so input is closed right after a transaction.
    `MBE_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "second point accepted while busy")

    // A zero count always maps to the space glyph.
    `MBE_ASSERT(a_zero_space, m_valid && m_escape_count == '0 |-> m_glyph_code == GLYPH_W'(GLYPH_SPACE), "zero count without space glyph")

    // Glyph is either the space or a letter code.
    `MBE_ASSERT(a_glyph_range, m_valid |-> m_glyph_code == GLYPH_W'(GLYPH_SPACE) || (m_glyph_code > GLYPH_W'(GLYPH_BASE) && m_glyph_code < GLYPH_W'(GLYPH_BASE + GLYPH_MOD)), "glyph code out of range")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_escape_count (m_escape_count),
    .m_glyph_code   (m_glyph_code)
);

FILE: tb/escape_result_checker.sv
`timescale 1ns / 1ps

module escape_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [mbe_pkg::IN_W-1:0]     s_point_real,
    input  logic signed [mbe_pkg::IN_W-1:0]     s_point_imag,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [mbe_pkg::COUNT_WIDTH-1:0]     m_escape_count,
    input  logic [mbe_pkg::GLYPH_W-1:0]         m_glyph_code,
    output int                                  mismatches,
    output int                                  outstanding
);
    import mbe_pkg::*;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [GLYPH_W-1:0]     glyph;
    } escape_result_t;

    localparam longint COUNT_TOP = (longint'(1) << COUNT_WIDTH) - 1;

    logic [ESC_W-1:0]  escape_limit;
    logic [ITER_W-1:0] iteration_limit;
    escape_result_t    expected_escapes[$];
    int                errors;
    int                results_seen;

    assign mismatches = errors;

    function automatic longint clamp48(input longint x);
        if (x > longint'(VAL_MAX)) begin
            return longint'(VAL_MAX);
        end
        if (x < longint'(VAL_MIN)) begin
            return longint'(VAL_MIN);
        end
        return x;
    endfunction

    // Exact product of the magnitudes, truncated toward zero, then clamped.
    function automatic longint fixed_mul_sat(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] cap;
        logic         neg;
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        neg  = (a < 0) != (b < 0);
        prod = {64'd0, ma} * {64'd0, mb};
        prod = prod >> FRAC_BITS;
        cap  = neg ? (128'd1 << (VAL_W - 1)) : ((128'd1 << (VAL_W - 1)) - 128'd1);
        if (prod > cap) begin
            prod = cap;
        end
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic escape_result_t predict_escape(
        input logic signed [IN_W-1:0] re,
        input logic signed [IN_W-1:0] im,
        input logic [ESC_W-1:0]       esc,
        input logic [ITER_W-1:0]      iter
    );
        longint         cr;
        longint         ci;
        longint         zr;
        longint         zi;
        longint         rr;
        longint         ri;
        longint         rc;
        longint         thresh;
        longint         count;
        longint         answer;
        longint         rem;
        bit             done;
        escape_result_t res;
        cr     = longint'(re);
        ci     = longint'(im);
        zr     = 0;
        zi     = 0;
        count  = 0;
        answer = 0;
        done   = 1'b0;
        thresh = longint'(esc) << FRAC_BITS;
        while (!done) begin
            rr    = fixed_mul_sat(zr, zr);
            ri    = fixed_mul_sat(zi, zi);
            rc    = fixed_mul_sat(zr, zi);
            zr    = clamp48(clamp48(rr - ri) + cr);
            zi    = clamp48(clamp48(rc + rc) + ci);
            count = count + 1;
            // The escape test looks at z from before this update.
            if (rr + ri > thresh) begin
                answer = count;
                done   = 1'b1;
            end else if (count > longint'(iter)) begin
                answer = 0;
                done   = 1'b1;
            end
        end
        if (answer > COUNT_TOP) begin
            answer = COUNT_TOP;
        end
        rem       = answer % GLYPH_MOD;
        res.count = answer[COUNT_WIDTH-1:0];
        res.glyph = (rem == 0) ? GLYPH_W'(GLYPH_SPACE) : GLYPH_W'(GLYPH_BASE + rem);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, results_seen);
        errors++;
    endtask

    always @(posedge aclk) begin
        escape_result_t want;
        if (!aresetn) begin
            escape_limit    = ESC_RESET;
            iteration_limit = ITER_RESET;
            expected_escapes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_escapes.size() == 0) begin
                    report_mismatch("result with no pending point",
                                    longint'(m_escape_count), 0);
                end else begin
                    want = expected_escapes.pop_front();
                    if (m_escape_count !== want.count) begin
                        report_mismatch("escape_count", longint'(m_escape_count),
                                        longint'(want.count));
                    end
                    if (m_glyph_code !== want.glyph) begin
                        report_mismatch("glyph_code", longint'(m_glyph_code),
                                        longint'(want.glyph));
                    end
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                expected_escapes.push_back(predict_escape(s_point_real, s_point_imag,
                                                          escape_limit, iteration_limit));
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_ESCAPE_LIMIT) begin
                    escape_limit = cfg_data[ESC_W-1:0];
                end else if (cfg_index == REG_ITERATION_LIMIT) begin
                    iteration_limit = cfg_data[ITER_W-1:0];
                end
            end
        end
        outstanding <= expected_escapes.size();
    end

endmodule

FILE: tb/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
    import mbe_pkg::*;

    // One unit in the block's Q3.28 format and a few landmarks of the set.
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int QUARTER   = ONE / 4;
    localparam int CUSP_STEP = 1 << (FRAC_BITS - 20);
    localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};

    // Points whose real part is at least 2.5 away from zero escape within a
    // handful of iterations, which keeps the maximum iteration limit affordable.
    localparam int FAR_MIN = (ONE / 2) * 5;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int LONG_HOLD       = 2500;
    localparam int DRAIN_CYCLES    = 64;
    // The slowest legal stretch without any transaction is the slow-escape point
    // near the cusp at the largest iteration limit: about 3300 iterations. The
    // limit below leaves a wide margin over that.
    localparam int WATCHDOG_LIMIT  = 100000;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [CFG_W-1:0]        cfg_data       = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_point_real   = '0;
    logic signed [IN_W-1:0]  s_point_imag   = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [COUNT_WIDTH-1:0]  m_escape_count;
    logic [GLYPH_W-1:0]      m_glyph_code;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit steady_sender = 1'b0;

    mandelbrot_escape_time u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_real   (s_point_real),
        .s_point_imag   (s_point_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_glyph_code   (m_glyph_code)
    );

    // The checker sees exactly what crosses the ports and predicts every
    // result on its own; this module only drives stimulus and rules on it.
    escape_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_real   (s_point_real),
        .s_point_imag   (s_point_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_glyph_code   (m_glyph_code),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gap lengths shared by both channels: mostly none or short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(3, 1);
        end else if (roll < 97) begin
            return $urandom_range(15, 4);
        end
        return $urandom_range(120, 30);
    endfunction

    function automatic logic signed [IN_W-1:0] corner_value();
        case ($urandom_range(4))
            0: return IN_MIN;
            1: return IN_MAX;
            2: return '0;
            3: return IN_W'(-1);
            default: return IN_W'(1);
        endcase
    endfunction

    // Most points land in the box around the set, where the interesting
    // orbits live; the rest cover the full input range, the edges of the set
    // and the corners of the fields.
    task automatic random_point(input bit far_only,
                                output logic signed [IN_W-1:0] re,
                                output logic signed [IN_W-1:0] im);
        int roll;
        int mag;
        roll = $urandom_range(99);
        if (far_only) begin
            mag = $urandom_range(int'(IN_MAX), FAR_MIN);
            re  = $urandom_range(1) ? IN_W'(mag) : IN_W'(-mag);
            im  = IN_W'($urandom());
        end else if (roll < 65) begin
            re = IN_W'(int'($urandom_range(3 * ONE)) - QUARTER * 9);
            im = IN_W'(int'($urandom_range(3 * ONE)) - (ONE / 2) * 3);
        end else if (roll < 80) begin
            re = IN_W'($urandom());
            im = IN_W'($urandom());
        end else if (roll < 92) begin
            case ($urandom_range(2))
                0: begin
                    // Just around the cusp, where orbits linger for long.
                    re = IN_W'(QUARTER + int'($urandom_range(1 << 16)) - (1 << 15));
                    im = IN_W'(int'($urandom_range(1 << 12)) - (1 << 11));
                end
                1: begin
                    // Along the tip of the real axis near -2.
                    re = IN_W'(-2 * ONE + int'($urandom_range(1 << 20)));
                    im = '0;
                end
                default: begin
                    re = IN_W'(int'($urandom_range(3 * ONE)) - QUARTER * 9);
                    im = '0;
                end
            endcase
        end else begin
            re = corner_value();
            im = corner_value();
        end
    endtask

    // Offer one point, after a random gap unless the sender runs steady. Valid
    // is only lowered when a gap follows, so back-to-back transactions keep it
    // high without a second assignment in the same time step.
    task automatic send_point(input logic signed [IN_W-1:0] re,
                              input logic signed [IN_W-1:0] im);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_real <= re;
        s_point_imag <= im;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering points and wait until every predicted result has been
    // delivered; the block is idle after that, so the registers may change.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // The upper byte of an escape_limit write is junk on purpose: only the low
    // eight bits belong to that register.
    task automatic set_limits(input logic [ESC_W-1:0] esc, input logic [ITER_W-1:0] iter);
        write_reg(REG_ESCAPE_LIMIT, {8'($urandom()), esc});
        write_reg(REG_ITERATION_LIMIT, iter);
    endtask

    // Watchdog: count cycles in which neither channel completes a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("mandelbrot_escape_time test failed");
        $finish;
    end

    // Result side. Ready alternates between random stalls and open stretches,
    // some of them long with no stall at all. Twice during the run it holds
    // off for a long stretch while the sender keeps offering points, so the
    // output register and the iteration engine both fill and s_ready drops.
    initial begin : result_sink
        int stall_left;
        int open_left;
        int hold_left;
        int results_seen;
        bit first_hold_done;
        bit second_hold_done;
        stall_left       = 0;
        open_left        = 0;
        hold_left        = 0;
        results_seen     = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!first_hold_done && results_seen >= 60) begin
                first_hold_done = 1'b1;
                hold_left       = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!second_hold_done && results_seen >= 700) begin
                second_hold_done = 1'b1;
                hold_left        = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0 && open_left == 0) begin
                    stall_left = pick_gap();
                    open_left  = ($urandom_range(9) == 0) ? $urandom_range(600, 200)
                                                          : $urandom_range(12, 1);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    open_left--;
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int                     p;
        int                     n;
        logic [ESC_W-1:0]       esc;
        logic [ITER_W-1:0]      iter;
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points at the reset limits (escape 4, 255 iterations).
        send_point('0, '0);                         // origin, never escapes
        send_point(IN_MAX, IN_MAX);                 // field extremes
        send_point(IN_MIN, IN_MIN);
        send_point(IN_MIN, IN_MAX);
        send_point(IN_MAX, '0);
        send_point('0, IN_MIN);
        send_point(IN_W'(-2 * ONE), '0);            // orbit pinned at |z|^2 = 4
        send_point(IN_W'(QUARTER), '0);             // the cusp itself
        send_point(IN_W'(QUARTER + CUSP_STEP), '0); // just outside, very slow
        send_point('0, IN_W'(ONE));                 // i, a bounded cycle
        send_point(IN_W'(-ONE), '0);                // period-two orbit
        send_point(IN_W'(ONE), '0);
        send_point(IN_W'(2 * ONE), '0);
        send_point(IN_W'(-1), IN_W'(-1));           // one LSB below zero
        send_point(IN_W'(1), IN_W'(1));
        drain_results();

        // A zero iteration limit gives a zero count whatever the point.
        set_limits(ESC_RESET, '0);
        send_point('0, '0);
        send_point(IN_MAX, IN_MIN);
        send_point(IN_W'(ONE), IN_W'(ONE));
        drain_results();

        // A zero escape limit lets almost everything out on the second step;
        // the origin stays, and so does a point too small to square above zero.
        set_limits('0, ITER_RESET);
        send_point('0, '0);
        send_point(IN_W'(1), '0);
        send_point('0, IN_W'(-1));
        send_point(IN_W'(ONE / 2), '0);
        send_point(IN_MIN, '0);
        drain_results();

        // Both limits at their top values. Only escaping points are sent here;
        // the one near the cusp takes a few thousand iterations.
        set_limits({ESC_W{1'b1}}, {ITER_W{1'b1}});
        send_point(IN_MIN, IN_MIN);
        send_point(IN_MAX, '0);
        send_point(IN_W'(QUARTER + CUSP_STEP), '0);
        send_point(IN_W'((ONE / 10) * 3), '0);
        drain_results();

        // Random phases. Each picks a fresh pair of limits, mostly with short
        // iteration limits to keep the run affordable, two phases at the reset
        // iteration limit and one at the maximum with fast-escaping points.
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: esc = ESC_W'($urandom_range(255));
                1: esc = ESC_RESET;
                2: esc = {ESC_W{1'b1}};
                default: esc = ESC_W'($urandom_range(8, 1));
            endcase
            if (p == NUM_PHASES - 1) begin
                esc = '0;
            end
            if (p == 5) begin
                iter = {ITER_W{1'b1}};
            end else if (p == 2 || p == 9) begin
                iter = ITER_RESET;
            end else if (p == 0) begin
                iter = ITER_W'($urandom_range(8, 1));
            end else begin
                iter = ITER_W'($urandom_range(40));
            end
            set_limits(esc, iter);
            steady_sender = (p % 3 == 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_point(p == 5, re, im);
                send_point(re, im);
            end
            drain_results();
        end

        // Give a stray extra result a chance to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("mandelbrot_escape_time test passed");
        end else begin
            $display("mandelbrot_escape_time test failed");
        end
        $finish;
    end

endmodule
